// ===== hdl/utu_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and constants of the utf-8 to utf-16 transcoder
package utu_pkg;

   localparam int COUNT_BITS_DEF = 16;
   localparam int IN_BITS        = 8;
   localparam int UNIT_BITS      = 16;
   localparam int ACC_BITS       = 21;
   localparam int PAIR_BITS      = 20;
   localparam int HALF_BITS      = 10;
   // result queue depth, a power of two
   localparam int FIFO_DEPTH     = 4;

   localparam logic [IN_BITS-1:0]   CONT_LOW   = 8'h80;
   localparam logic [IN_BITS-1:0]   LEAD2_LOW  = 8'hC0;
   localparam logic [IN_BITS-1:0]   LEAD3_LOW  = 8'hE0;
   localparam logic [IN_BITS-1:0]   LEAD4_LOW  = 8'hF0;
   localparam logic [IN_BITS-1:0]   LEAD_BAD   = 8'hF8;
   localparam logic [ACC_BITS-1:0]  CODE_MAX   = 21'h10FFFF;
   localparam logic [ACC_BITS-1:0]  SUPP_BASE  = 21'h010000;
   localparam logic [UNIT_BITS-1:0] HI_SURR    = 16'hD800;
   localparam logic [UNIT_BITS-1:0] LO_SURR    = 16'hDC00;
   localparam logic [UNIT_BITS-1:0] TOTAL_MAX  = 16'hFFFF;

   typedef enum logic [1:0] {
      KIND_UNIT = 2'd0,
      KIND_END  = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0]          pending;
      logic [ACC_BITS-1:0] acc;
      logic                four;
      logic                discarding;
   } seq_state_type;

   typedef struct packed {
      logic [UNIT_BITS-1:0] code_unit;
      kind_type             kind;
      logic [UNIT_BITS-1:0] unit_total;
      logic                 last_of_run;
   } result_type;

endpackage

// ===== hdl/utu_decode.sv =====
`timescale 1ns / 1ps
// combinational byte decoder: next sequence state and up to two results
module utu_decode #(
   parameter int COUNT_BITS = utu_pkg::COUNT_BITS_DEF
) (
   input  logic [utu_pkg::IN_BITS-1:0] in_byte,
   input  utu_pkg::seq_state_type      st,
   input  logic [COUNT_BITS-1:0]       count,
   output utu_pkg::seq_state_type      st_in,
   output logic [COUNT_BITS-1:0]       count_in,
   output logic [1:0]                  num_results,
   output utu_pkg::result_type         res0,
   output utu_pkg::result_type         res1
);
   import utu_pkg::*;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   logic [COUNT_BITS-1:0] cnt1;
   logic [COUNT_BITS-1:0] cnt2;
   logic [ACC_BITS-1:0]   acc_ext;
   logic [ACC_BITS-1:0]   acc_off;
   logic [PAIR_BITS-1:0]  pair_val;
   logic [1:0]            pend_dec;
   logic                  is_cont;

   function automatic logic [UNIT_BITS-1:0] view(input logic [COUNT_BITS-1:0] c);
      logic [31:0] wide;
      wide = 32'(c);
      return (wide > 32'(TOTAL_MAX)) ? TOTAL_MAX : wide[UNIT_BITS-1:0];
   endfunction

   // saturating unit counters for one and two emitted units
   assign cnt1     = (count == CNT_MAX) ? count : count + 1'b1;
   assign cnt2     = (cnt1 == CNT_MAX) ? cnt1 : cnt1 + 1'b1;
   assign acc_ext  = {st.acc[ACC_BITS-7:0], in_byte[5:0]};
   assign acc_off  = acc_ext - SUPP_BASE;
   assign pair_val = acc_off[PAIR_BITS-1:0];
   assign pend_dec = st.pending - 2'd1;
   assign is_cont  = (in_byte >= CONT_LOW) && (in_byte < LEAD2_LOW);

   always_comb begin
      st_in       = st;
      count_in    = count;
      num_results = 2'd0;
      res0        = '{code_unit: '0, kind: KIND_ERR, unit_total: view(count), last_of_run: 1'b1};
      res1        = '{code_unit: '0, kind: KIND_UNIT, unit_total: view(cnt2), last_of_run: 1'b1};
      priority if (in_byte == '0) begin
         // terminator: clears everything, reports unless swallowing
         st_in    = '0;
         count_in = '0;
         if (!st.discarding) begin
            num_results = 2'd1;
            if (st.pending == 2'd0) begin
               res0.kind = KIND_END;
            end
         end
      end else if (st.discarding) begin
         // swallowed
      end else if (st.pending != 2'd0) begin
         priority if (!is_cont) begin
            st_in            = '0;
            st_in.discarding = 1'b1;
            num_results      = 2'd1;
         end else if (pend_dec != 2'd0) begin
            st_in.pending = pend_dec;
            st_in.acc     = acc_ext;
         end else if (st.four && (acc_ext > CODE_MAX)) begin
            st_in            = '0;
            st_in.discarding = 1'b1;
            num_results      = 2'd1;
         end else if (st.four) begin
            // surrogate pair, high half first
            st_in                = '0;
            count_in             = cnt2;
            num_results          = 2'd2;
            res0.code_unit       = HI_SURR | UNIT_BITS'(pair_val[PAIR_BITS-1:HALF_BITS]);
            res0.kind            = KIND_UNIT;
            res0.unit_total      = view(cnt1);
            res0.last_of_run     = 1'b0;
            res1.code_unit       = LO_SURR | UNIT_BITS'(pair_val[HALF_BITS-1:0]);
         end else begin
            st_in           = '0;
            count_in        = cnt1;
            num_results     = 2'd1;
            res0.code_unit  = acc_ext[UNIT_BITS-1:0];
            res0.kind       = KIND_UNIT;
            res0.unit_total = view(cnt1);
         end
      end else begin
         priority if (in_byte < CONT_LOW) begin
            count_in        = cnt1;
            num_results     = 2'd1;
            res0.code_unit  = UNIT_BITS'(in_byte);
            res0.kind       = KIND_UNIT;
            res0.unit_total = view(cnt1);
         end else if (in_byte < LEAD2_LOW) begin
            st_in            = '0;
            st_in.discarding = 1'b1;
            num_results      = 2'd1;
         end else if (in_byte < LEAD3_LOW) begin
            st_in.acc     = ACC_BITS'(in_byte[4:0]);
            st_in.pending = 2'd1;
            st_in.four    = 1'b0;
         end else if (in_byte < LEAD4_LOW) begin
            st_in.acc     = ACC_BITS'(in_byte[3:0]);
            st_in.pending = 2'd2;
            st_in.four    = 1'b0;
         end else if (in_byte < LEAD_BAD) begin
            st_in.acc     = ACC_BITS'(in_byte[2:0]);
            st_in.pending = 2'd3;
            st_in.four    = 1'b1;
         end else begin
            st_in            = '0;
            st_in.discarding = 1'b1;
            num_results      = 2'd1;
         end
      end
   end

endmodule

// ===== hdl/utu_result_fifo.sv =====
`timescale 1ns / 1ps
// small result queue taking up to two items per cycle and giving one
module utu_result_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_n,
   input  utu_pkg::result_type push0,
   input  utu_pkg::result_type push1,
   input  logic                out_ready,
   output logic                out_valid,
   output utu_pkg::result_type head,
   output logic                room_for_two
);
   import utu_pkg::*;

   localparam int PTR_BITS  = $clog2(FIFO_DEPTH);
   localparam int FILL_BITS = $clog2(FIFO_DEPTH + 1);

   result_type           mem_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]  wr_ff;
   logic [PTR_BITS-1:0]  wr_in;
   logic [PTR_BITS-1:0]  wr_next;
   logic [PTR_BITS-1:0]  rd_ff;
   logic [PTR_BITS-1:0]  rd_in;
   logic [FILL_BITS-1:0] fill_ff;
   logic [FILL_BITS-1:0] fill_in;
   logic                 pop;

   assign wr_next      = wr_ff + 1'b1;
   assign pop          = out_valid && out_ready;
   assign out_valid    = (fill_ff != '0);
   assign head         = mem_ff[rd_ff];
   assign room_for_two = (fill_ff <= FILL_BITS'(FIFO_DEPTH - 2));
   assign wr_in        = wr_ff + PTR_BITS'(push_n);
   assign rd_in        = rd_ff + PTR_BITS'(pop);
   assign fill_in      = fill_ff + FILL_BITS'(push_n) - FILL_BITS'(pop);

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_next] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// ===== hdl/utf8_to_utf16_transcoder_core.sv =====
`timescale 1ns / 1ps
// top level of the utf-8 to utf-16 transcoder
// path: an accepted byte is registered in the input stage and decoded there; its results are
//   registered in the result queue, which offers them on rsp
// throughput: one byte per cycle while the queue has room for two results; a four-byte sequence
//   ends in two results, which leave through the single result port (a four-entry queue absorbs them)
// stalls: the staged byte waits while the queue holds three or more results
// reset: synchronous, active high; clears sequence state, unit count, input stage and queue
module utf8_to_utf16_transcoder_core #(
   parameter int COUNT_BITS = utu_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] code_unit, [31:16] unit_total
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last_of_run
);
   import utu_pkg::*;

   // input stage
   logic                  in_vld_ff;
   logic                  in_vld_in;
   logic [IN_BITS-1:0]    in_byte_ff;

   // sequence state and unit count
   seq_state_type         st_ff;
   seq_state_type         st_in;
   seq_state_type         st_dec;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [COUNT_BITS-1:0] count_dec;

   logic [1:0]            num_results;
   logic [1:0]            push_n;
   result_type            res0;
   result_type            res1;
   result_type            head;
   logic                  room_for_two;
   logic                  advance;
   logic                  req_take;

   // the staged byte is decoded once the queue can hold both halves of a pair
   assign advance    = in_vld_ff && room_for_two;
   assign req_tready = !in_vld_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign in_vld_in  = req_take || (in_vld_ff && !advance);
   assign push_n     = advance ? num_results : 2'd0;
   assign st_in      = advance ? st_dec : st_ff;
   assign count_in   = advance ? count_dec : count_ff;

   utu_decode #(
      .COUNT_BITS (COUNT_BITS)
   ) u_decode (
      .in_byte     (in_byte_ff),
      .st          (st_ff),
      .count       (count_ff),
      .st_in       (st_dec),
      .count_in    (count_dec),
      .num_results (num_results),
      .res0        (res0),
      .res1        (res1)
   );

   utu_result_fifo u_result_fifo (
      .clock        (clock),
      .reset        (reset),
      .push_n       (push_n),
      .push0        (res0),
      .push1        (res1),
      .out_ready    (rsp_tready),
      .out_valid    (rsp_tvalid),
      .head         (head),
      .room_for_two (room_for_two)
   );

   assign rsp_tdata = {head.unit_total, head.code_unit};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last_of_run;

   // payload of the input stage needs no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         st_ff     <= '0;
         count_ff  <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         st_ff     <= st_in;
         count_ff  <= count_in;
      end
   end

   // an error clears the sequence before swallowing starts
   assert property (@(posedge clock) disable iff (reset)
      st_ff.discarding |-> (st_ff.pending == 2'd0))
      else $error("discarding with continuation bytes pending");

   // the four-byte flag only lives inside an open sequence
   assert property (@(posedge clock) disable iff (reset)
      st_ff.four |-> (st_ff.pending != 2'd0))
      else $error("four-byte flag set outside a sequence");

   // three pending bytes only follow a four-byte lead
   assert property (@(posedge clock) disable iff (reset)
      (st_ff.pending == 2'd3) |-> st_ff.four)
      else $error("three pending bytes without four-byte lead");

   // a reset leaves nothing staged and nothing offered
   assert property (@(posedge clock)
      $past(reset) |-> (!rsp_tvalid && !in_vld_ff && (count_ff == '0)))
      else $error("state left after reset");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the utf-8 to utf-16 transcoder: directed and random runs
module tb;
   import utu_pkg::*;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RANDOM_ITEMS    = 900;

   // decodes accepted bytes into expected code units and checks what the block returns
   class utf16_unit_board;
      result_type      units_due[$];
      logic [1:0]      pending;
      logic [20:0]     acc;
      logic            four;
      logic            discarding;
      longint unsigned unit_count;
      int              errors;
      int              bytes_seen;
      int              units_seen;
      int              pairs_due;
      int              ends_seen;
      int              fails_seen;

      function new();
         clear_all();
         errors = 0;
         bytes_seen = 0;
         units_seen = 0;
         pairs_due = 0;
         ends_seen = 0;
         fails_seen = 0;
      endfunction

      function void clear_all();
         pending = 0;
         acc = 0;
         four = 0;
         unit_count = 0;
         discarding = 0;
      endfunction

      function void bump();
         if (unit_count < ((64'd1 << COUNT_BITS_DEF) - 1)) unit_count++;
      endfunction

      function void emit(logic [15:0] cu, kind_type k, logic last);
         result_type r;
         r.code_unit = cu;
         r.kind = k;
         r.unit_total = (unit_count > TOTAL_MAX) ? TOTAL_MAX : unit_count[15:0];
         r.last_of_run = last;
         units_due.push_back(r);
      endfunction

      // error result, then swallow bytes up to the terminator
      function void flag_error();
         emit(16'h0000, KIND_ERR, 1'b1);
         pending = 0;
         acc = 0;
         four = 0;
         discarding = 1;
      endfunction

      function void note_byte(logic [7:0] b);
         logic [19:0] v;
         bytes_seen++;
         if (b == 8'h00) begin
            // terminator: end report, error if cut inside a sequence, silent while swallowing
            if (!discarding) emit(16'h0000, (pending != 0) ? KIND_ERR : KIND_END, 1'b1);
            clear_all();
         end else if (discarding) begin
            // swallowed
         end else if (pending != 0) begin
            if (b < CONT_LOW || b >= LEAD2_LOW) begin
               flag_error();
            end else begin
               acc = {acc[14:0], b[5:0]};
               pending = pending - 1;
               if (pending == 0) begin
                  if (four && acc > CODE_MAX) begin
                     flag_error();
                  end else if (four) begin
                     // overlong values wrap modulo 2^20 before the split
                     v = acc[19:0] - SUPP_BASE[19:0];
                     bump();
                     emit(HI_SURR | {6'd0, v[19:10]}, KIND_UNIT, 1'b0);
                     bump();
                     emit(LO_SURR | {6'd0, v[9:0]}, KIND_UNIT, 1'b1);
                     pairs_due++;
                     acc = 0;
                     four = 0;
                  end else begin
                     bump();
                     emit(acc[15:0], KIND_UNIT, 1'b1);
                     acc = 0;
                  end
               end
            end
         end else if (b < CONT_LOW) begin
            bump();
            emit({8'h00, b}, KIND_UNIT, 1'b1);
         end else if (b < LEAD2_LOW) begin
            flag_error();
         end else if (b < LEAD3_LOW) begin
            acc = {16'd0, b[4:0]};
            pending = 1;
            four = 0;
         end else if (b < LEAD4_LOW) begin
            acc = {17'd0, b[3:0]};
            pending = 2;
            four = 0;
         end else if (b < LEAD_BAD) begin
            acc = {18'd0, b[2:0]};
            pending = 3;
            four = 1;
         end else begin
            flag_error();
         end
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= 50) $display("mismatch at %0t ns: %s", $time, what);
      endtask

      task check_unit(logic [15:0] cu, logic [1:0] k, logic [15:0] total, logic last);
         result_type want;
         if (units_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result unit %h kind %0d total %0d",
                                      cu, k, total));
            return;
         end
         want = units_due.pop_front();
         units_seen++;
         if (k == KIND_END) ends_seen++;
         if (k == KIND_ERR) fails_seen++;
         if (cu !== want.code_unit)
            report_mismatch($sformatf("code_unit %h, expected %h", cu, want.code_unit));
         if (k !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", k, want.kind));
         if (total !== want.unit_total)
            report_mismatch($sformatf("unit_total %0d, expected %0d", total, want.unit_total));
         if (last !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, expected %b", last, want.last_of_run));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   utf16_unit_board board = new();
   logic [7:0]      text_bytes[$];
   int              tx_gap_max;
   int              rx_stall_max;
   int              burst_left;
   int              items_sent;
   int              strings_sent;
   int              hold_off_asked;
   int              hold_off_done;

   utf8_to_utf16_transcoder_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("timeout: run did not finish, %0d results still due", board.units_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // one byte onto the input, in bursts separated by random gaps
   task automatic push_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            req_tdata <= 8'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      board.note_byte(b);
      items_sent++;
      if (b == 8'h00) strings_sent++;
   endtask

   task automatic send_text();
      foreach (text_bytes[i]) push_byte(text_bytes[i]);
      text_bytes.delete();
   endtask

   function automatic void add_code_point(logic [20:0] cp, int nbytes);
      case (nbytes)
         1: text_bytes.push_back({1'b0, cp[6:0]});
         2: begin
            text_bytes.push_back({3'b110, cp[10:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
         end
         3: begin
            text_bytes.push_back({4'b1110, cp[15:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
         end
         default: begin
            text_bytes.push_back({5'b11110, cp[20:18]});
            text_bytes.push_back({2'b10, cp[17:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   // one zero-terminated string; noisy ones carry broken sequences and stray bytes
   task automatic compose_string(input bit noisy);
      int n;
      int r;
      n = $urandom_range(0, 10);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (noisy && r < 12) begin
            case ($urandom_range(0, 3))
               0: text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
               1: text_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
               2: begin
                  // lead byte followed by something that is not a continuation
                  text_bytes.push_back(8'($urandom_range(8'hC0, 8'hF7)));
                  if ($urandom_range(0, 1))
                     text_bytes.push_back(8'($urandom_range(1, 8'h7F)));
                  else
                     text_bytes.push_back(8'($urandom_range(8'hC0, 8'hFF)));
               end
               default: text_bytes.push_back(8'($urandom_range(1, 255)));
            endcase
         end else if (r < 35) begin
            add_code_point(21'($urandom_range(1, 8'h7F)), 1);
         end else if (r < 55) begin
            add_code_point(21'($urandom_range(0, 16'h07FF)), 2);
         end else if (r < 75) begin
            add_code_point(21'($urandom_range(0, 16'hFFFF)), 3);
         end else if (r < 92) begin
            add_code_point(21'($urandom_range(32'h10000, 32'h10FFFF)), 4);
         end else begin
            // any 21-bit value: overlong and out-of-range ones too
            add_code_point(21'($urandom_range(0, 32'h1FFFFF)), 4);
         end
      end
      // string ending in the middle of a sequence
      if (noisy && $urandom_range(0, 3) == 0)
         text_bytes.push_back(8'($urandom_range(8'hC0, 8'hF7)));
      text_bytes.push_back(8'h00);
   endtask

   // result side: checks every accepted item and stalls on its own run-length pattern
   initial begin
      int stall_run;
      int go_run;
      stall_run = 0;
      go_run = 0;
      hold_off_done = 0;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            board.check_unit(rsp_tdata[15:0], rsp_tuser, rsp_tdata[31:16], rsp_tlast);
         if (hold_off_done != hold_off_asked) begin
            // long hold-off so the result queue fills and the input backs up
            hold_off_done++;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         if (stall_run > 0) begin
            rsp_tready <= 1'b0;
            stall_run--;
         end else if (go_run > 0) begin
            rsp_tready <= 1'b1;
            go_run--;
         end else begin
            go_run = $urandom_range(1, 12);
            stall_run = (rx_stall_max > 0) ? $urandom_range(0, rx_stall_max) : 0;
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int phase_items;
      int guard;
      int gaps[5];
      int stalls[5];
      gaps = '{0, 4, 0, 10, 2};
      stalls = '{0, 3, 8, 0, 2};
      tx_gap_max = 0;
      rx_stall_max = 0;
      burst_left = 0;
      items_sent = 0;
      strings_sent = 0;
      hold_off_asked = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: largest one-byte, smallest two-byte and largest three-byte values, U+10FFFF, empty string
      text_bytes = '{8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                     8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00, 8'h00};
      send_text();
      // overlong four-byte value, value above U+10FFFF, then swallowed bytes and zero
      text_bytes = '{8'hF0, 8'h80, 8'h80, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80, 8'hFF, 8'h00};
      send_text();
      // bad lead byte, and a string cut inside a sequence
      text_bytes = '{8'hFF, 8'h00, 8'hE2, 8'h00};
      send_text();

      // random strings under varying input gaps and output stalls
      for (int p = 0; p < 5; p++) begin
         tx_gap_max = gaps[p];
         rx_stall_max = stalls[p];
         if (p == 2) hold_off_asked = hold_off_asked + 1;
         phase_items = 0;
         while (phase_items < RANDOM_ITEMS / 5) begin
            compose_string($urandom_range(0, 3) == 0);
            phase_items += text_bytes.size();
            send_text();
         end
      end
      req_tvalid <= 1'b0;

      guard = 0;
      while (board.units_due.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.units_due.size() != 0)
         board.report_mismatch($sformatf("%0d expected results never arrived",
                                         board.units_due.size()));

      $display("run: %0d bytes in %0d strings, %0d results (%0d surrogate pairs,",
               items_sent, strings_sent, board.units_seen, board.pairs_due);
      $display("run: %0d ends, %0d errors), %0d long output hold-offs, %0d mismatches",
               board.ends_seen, board.fails_seen, hold_off_done, board.errors);
      if (board.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
